// File: rtl/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
`default_nettype none
package u16u8_pkg;

	localparam int MAX_BYTES = 6;
	localparam int CNT_W     = 3;

	localparam logic [15:0] MASK_ASCII = 16'hFF80;
	localparam logic [15:0] MASK_TWO   = 16'hF800;
	localparam logic [15:0] MASK_SURR  = 16'hFC00;
	localparam logic [15:0] HIGH_SURR  = 16'hD800;
	localparam logic [15:0] LOW_SURR   = 16'hDC00;
	localparam logic [7:0]  LEAD_TWO   = 8'hC0;
	localparam logic [7:0]  CONT_MARK  = 8'h80;
	localparam logic [7:0]  LEAD_THREE = 8'hE0;
	localparam logic [7:0]  LEAD_FOUR  = 8'hF0;
	localparam logic [7:0]  CONT_MASK  = 8'h3F;

	typedef logic [7:0] octet_t;

	// Bytes of one unit's result, bytes[0] goes out first.
	typedef struct packed {
		octet_t [MAX_BYTES-1:0] bytes;
		logic [CNT_W-1:0]       cnt;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage
`default_nettype wire

// File: rtl/u16u8_front.sv
// Front end: accepts code units, tracks the held high surrogate, builds byte groups.
`default_nettype none
module u16u8_front (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  code_valid,
	output logic                       code_stall,
	input  wire logic [15:0]           code_unit,
	input  wire u16u8_pkg::q_status_t  q_status,
	output logic                       push,
	output u16u8_pkg::entry_t          push_entry
);

	logic [15:0] pending_high_q;
	logic        pending_valid_q;
	logic        accept;
	logic        is_low;
	logic        is_high;
	logic        pair;
	logic [20:0] cp;
	u16u8_pkg::octet_t [2:0] cur;
	logic [1:0]  cur_n;
	u16u8_pkg::octet_t [2:0] held;

	function automatic u16u8_pkg::octet_t [2:0] enc3(input logic [15:0] v);
		u16u8_pkg::octet_t [2:0] r;
		r[0] = {4'h0, v[15:12]} | u16u8_pkg::LEAD_THREE;
		r[1] = ({2'b00, v[11:6]} & u16u8_pkg::CONT_MASK) | u16u8_pkg::CONT_MARK;
		r[2] = ({2'b00, v[5:0]} & u16u8_pkg::CONT_MASK) | u16u8_pkg::CONT_MARK;
		return r;
	endfunction

	assign code_stall = q_status.full;
	assign accept     = code_valid && !code_stall;
	assign is_low     = (code_unit & u16u8_pkg::MASK_SURR) == u16u8_pkg::LOW_SURR;
	assign is_high    = (code_unit & u16u8_pkg::MASK_SURR) == u16u8_pkg::HIGH_SURR;
	assign pair       = pending_valid_q && is_low;
	assign cp         = 21'h10000 + {1'b0, pending_high_q[9:0], code_unit[9:0]};
	assign held       = enc3(pending_high_q);

	always_comb begin
		cur   = '0;
		cur_n = 2'd0;
		if (code_unit == 16'h0000) begin
			cur_n = 2'd1;
		end else if ((code_unit & u16u8_pkg::MASK_ASCII) == 16'h0000) begin
			cur[0] = code_unit[7:0];
			cur_n  = 2'd1;
		end else if ((code_unit & u16u8_pkg::MASK_TWO) == 16'h0000) begin
			cur[0] = {3'b000, code_unit[10:6]} | u16u8_pkg::LEAD_TWO;
			cur[1] = {2'b00, code_unit[5:0]} | u16u8_pkg::CONT_MARK;
			cur_n  = 2'd2;
		end else if (!is_high) begin
			cur   = enc3(code_unit);
			cur_n = 2'd3;
		end
	end

	always_comb begin
		push_entry = '0;
		if (pair) begin
			push_entry.bytes[0] = {5'b00000, cp[20:18]} | u16u8_pkg::LEAD_FOUR;
			push_entry.bytes[1] = {2'b00, cp[17:12]} | u16u8_pkg::CONT_MARK;
			push_entry.bytes[2] = {2'b00, cp[11:6]} | u16u8_pkg::CONT_MARK;
			push_entry.bytes[3] = {2'b00, cp[5:0]} | u16u8_pkg::CONT_MARK;
			push_entry.cnt      = 3'd4;
		end else if (pending_valid_q) begin
			// flush the held unit ahead of the current one
			push_entry.bytes[2:0] = held;
			push_entry.bytes[5:3] = cur;
			push_entry.cnt        = 3'd3 + {1'b0, cur_n};
		end else begin
			push_entry.bytes[2:0] = cur;
			push_entry.cnt        = {1'b0, cur_n};
		end
	end

	assign push = accept && (push_entry.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_high_q  <= '0;
			pending_valid_q <= 1'b0;
		end else if (accept) begin
			if (!pair && is_high) begin
				pending_high_q  <= code_unit;
				pending_valid_q <= 1'b1;
			end else begin
				pending_high_q  <= '0;
				pending_valid_q <= 1'b0;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full) else $error("push into full queue");

endmodule
`default_nettype wire

// File: rtl/u16u8_queue.sv
// Small queue of byte groups between the front and back ends.
`default_nettype none
module u16u8_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire u16u8_pkg::entry_t push_entry,
	input  wire logic              pop,
	output u16u8_pkg::entry_t      head,
	output u16u8_pkg::q_status_t   status
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	u16u8_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head         = mem_q[rd_ptr_q];
	assign status.full  = count_q == FULL_CNT;
	assign status.empty = count_q == '0;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count overflow");

endmodule
`default_nettype wire

// File: rtl/u16u8_back.sv
// Back end: sends the bytes of each queued group, one beat per cycle while byte_stall is low.
`default_nettype none
module u16u8_back (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire u16u8_pkg::entry_t     head,
	input  wire u16u8_pkg::q_status_t  q_status,
	output logic                       pop,
	output logic                       byte_valid,
	input  wire logic                  byte_stall,
	output logic [7:0]                 out_byte,
	output logic                       last_of_run
);

	u16u8_pkg::entry_t cur_q;
	logic [u16u8_pkg::CNT_W-1:0] idx_q;
	logic busy_q;
	logic beat;

	assign byte_valid  = busy_q;
	assign out_byte    = cur_q.bytes[idx_q];
	assign last_of_run = (idx_q + 1'b1) == cur_q.cnt;
	assign beat        = byte_valid && !byte_stall;
	assign pop         = !q_status.empty && (!busy_q || (beat && last_of_run));

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (beat) begin
			if (last_of_run) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid |-> (idx_q < cur_q.cnt)) else $error("byte index past group end");

	a_group_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(beat && !last_of_run) |=> (byte_valid && idx_q == $past(idx_q) + 1'b1))
		else $error("group cut short");

endmodule
`default_nettype wire

// File: rtl/utf16_to_utf8_encoder_top.sv
// Top level of the UTF-16 to UTF-8 encoder.
// Takes one UTF-16 code unit per beat on the code channel and sends UTF-8 bytes, one per
// beat, on the byte channel; last_of_run marks the final byte caused by a unit. A code unit
// is accepted in any cycle in which the group queue (QUEUE_DEPTH entries, at least 2) is not
// full, so units flow back to back. The byte sequencer in the back end sends one byte per
// cycle while byte_stall is low. It yields 1 to 3 bytes for a plain unit, 4 for a
// surrogate pair (charged to the low half), up to 6 when a held high surrogate is flushed
// ahead of another unit, and 0 for a high surrogate that is held. A unit's bytes pass
// through the group queue and then the back end's group register before they appear. A
// zero unit flushes any held surrogate and sends a zero terminator byte.
`default_nettype none
module utf16_to_utf8_encoder_top #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        code_valid,
	output logic             code_stall,
	input  wire logic [15:0] code_unit,
	output logic             byte_valid,
	input  wire logic        byte_stall,
	output logic [7:0]       out_byte,
	output logic             last_of_run
);

	logic                 push;
	logic                 pop;
	u16u8_pkg::entry_t    push_entry;
	u16u8_pkg::entry_t    head;
	u16u8_pkg::q_status_t q_status;

	u16u8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.code_valid (code_valid),
		.code_stall (code_stall),
		.code_unit  (code_unit),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry)
	);

	u16u8_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	u16u8_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.out_byte    (out_byte),
		.last_of_run (last_of_run)
	);

endmodule
`default_nettype wire

// File: verif/utf16_to_utf8_encoder_top_test.sv
// Testbench for the UTF-16 to UTF-8 encoder: random handshakes, predicted byte stream, checks.
module utf16_to_utf8_encoder_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_UNITS = 370;
	localparam int CALM_TAIL    = 40;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		u16u8_pkg::octet_t value;
		logic              last;
	} utf8_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        code_valid = 1'b0;
	logic        code_stall;
	logic [15:0] code_unit = 16'h0000;
	logic        byte_valid;
	logic        byte_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last_of_run;

	logic [15:0] unit_queue[$];
	utf8_beat_t  utf8_expected[$];

	logic [15:0] held_high = 16'h0000;
	logic        held_valid = 1'b0;

	bit unit_taken = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int fail_count = 0;
	int cycle_count = 0;

	utf16_to_utf8_encoder_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.code_valid(code_valid),
		.code_stall(code_stall),
		.code_unit(code_unit),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.out_byte(out_byte),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// No idling once the tail of the stimulus is reached.
	function automatic bit calm();
		return unit_queue.size() < CALM_TAIL;
	endfunction

	function automatic void push_three(ref u16u8_pkg::octet_t seq[$], input logic [15:0] u);
		seq.push_back(u16u8_pkg::LEAD_THREE | {4'h0, u[15:12]});
		seq.push_back(u16u8_pkg::CONT_MARK | {2'b00, u[11:6]});
		seq.push_back(u16u8_pkg::CONT_MARK | {2'b00, u[5:0]});
	endfunction

	// Work out the bytes one accepted code unit yields and queue them.
	function automatic void predict_utf8(input logic [15:0] u);
		u16u8_pkg::octet_t seq[$];
		logic [20:0]       cp;
		bit                paired;
		paired = 1'b0;
		if (held_valid) begin
			if ((u & u16u8_pkg::MASK_SURR) == u16u8_pkg::LOW_SURR) begin
				cp = 21'h10000 + {1'b0, held_high[9:0], 10'h000} + {11'h000, u[9:0]};
				seq.push_back(u16u8_pkg::LEAD_FOUR | {5'h00, cp[20:18]});
				seq.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[17:12]});
				seq.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[11:6]});
				seq.push_back(u16u8_pkg::CONT_MARK | {2'b00, cp[5:0]});
				paired = 1'b1;
			end else begin
				push_three(seq, held_high);
			end
			held_valid = 1'b0;
			held_high = 16'h0000;
		end
		if (!paired) begin
			if (u == 16'h0000) begin
				seq.push_back(8'h00);
			end else if ((u & u16u8_pkg::MASK_ASCII) == 16'h0000) begin
				seq.push_back(u[7:0]);
			end else if ((u & u16u8_pkg::MASK_TWO) == 16'h0000) begin
				seq.push_back(u16u8_pkg::LEAD_TWO | {3'b000, u[10:6]});
				seq.push_back(u16u8_pkg::CONT_MARK | {2'b00, u[5:0]});
			end else if ((u & u16u8_pkg::MASK_SURR) == u16u8_pkg::HIGH_SURR) begin
				held_high = u;
				held_valid = 1'b1;
			end else begin
				push_three(seq, u);
			end
		end
		foreach (seq[i])
			utf8_expected.push_back('{value: seq[i], last: (i == seq.size() - 1)});
	endfunction

	// Monitor: observe both channels at the rising edge.
	always @(posedge clk) begin
		utf8_beat_t want;
		if (arst_n) begin
			if (code_valid && !code_stall) begin
				predict_utf8(code_unit);
				unit_taken = 1'b1;
			end
			if (byte_valid && !byte_stall) begin
				if (utf8_expected.size() == 0) begin
					$display("%0t: unexpected beat: expected none, actual %h last %b",
						$time, out_byte, last_of_run);
					fail_count++;
				end else begin
					want = utf8_expected.pop_front();
					if (out_byte !== want.value) begin
						$display("%0t: out_byte mismatch: expected %h, actual %h",
							$time, want.value, out_byte);
						fail_count++;
					end
					if (last_of_run !== want.last) begin
						$display("%0t: last_of_run mismatch: expected %b, actual %b",
							$time, want.last, last_of_run);
						fail_count++;
					end
				end
			end
		end
	end

	// Driver: feed code units at the falling edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!code_valid || unit_taken) begin
				unit_taken = 1'b0;
				if (send_gap == 0 && !calm() && $urandom_range(0, 4) == 0)
					send_gap = $urandom_range(1, 3);
				if (send_gap > 0) begin
					code_valid <= 1'b0;
					send_gap--;
				end else if (unit_queue.size() != 0) begin
					code_valid <= 1'b1;
					code_unit <= unit_queue.pop_front();
				end else begin
					code_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall the byte channel in short bursts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left == 0 && !calm() && $urandom_range(0, 4) == 0)
				stall_left = $urandom_range(1, 3);
			if (stall_left > 0) begin
				byte_stall <= 1'b1;
				stall_left--;
			end else begin
				byte_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d beats outstanding", $time, utf8_expected.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		int made;
		int pick;
		logic [15:0] after_high;

		// Directed: field extremes and surrogate corner cases.
		unit_queue = '{16'h0001, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hD7FF,
			16'hE000, 16'hFFFF, 16'h0000,
			16'hDC00, 16'hDFFF,
			16'hD800, 16'hDC00, 16'hDBFF, 16'hDFFF,
			16'hD83D, 16'h0041,
			16'hDBC0, 16'hD801, 16'hDC01,
			16'hD800, 16'h0800,
			16'hD812, 16'h0000};

		made = 0;
		while (made < RANDOM_UNITS) begin
			pick = $urandom_range(0, 11);
			case (pick)
				0, 1: begin
					unit_queue.push_back(16'($urandom_range(16'h0001, 16'h007F)));
					made++;
				end
				2: begin
					unit_queue.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
					made++;
				end
				3: begin
					if ($urandom_range(0, 1))
						unit_queue.push_back(16'($urandom_range(16'h0800, 16'hD7FF)));
					else
						unit_queue.push_back(16'($urandom_range(16'hE000, 16'hFFFF)));
					made++;
				end
				4, 5, 6: begin
					unit_queue.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
					unit_queue.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
					made += 2;
				end
				7: begin
					// Break the pair: follow a high half with anything but a low half.
					unit_queue.push_back(16'($urandom_range(16'hD800, 16'hDBFF)));
					case ($urandom_range(0, 3))
						0: after_high = 16'h0000;
						1: after_high = 16'($urandom_range(16'hD800, 16'hDBFF));
						2: after_high = 16'($urandom_range(16'h0001, 16'h07FF));
						default: after_high = 16'($urandom_range(16'hE000, 16'hFFFF));
					endcase
					unit_queue.push_back(after_high);
					made += 2;
				end
				8: begin
					unit_queue.push_back(16'($urandom_range(16'hDC00, 16'hDFFF)));
					made++;
				end
				9: begin
					unit_queue.push_back(16'($urandom_range(0, 16'hFFFF)));
					made++;
				end
				default: begin
					unit_queue.push_back(16'h0000);
					made++;
				end
			endcase
		end
		unit_queue.push_back(16'h0000);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (unit_queue.size() != 0 || code_valid)
			@(posedge clk);
		while (utf8_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
rtl/u16u8_pkg.sv
rtl/u16u8_front.sv
rtl/u16u8_queue.sv
rtl/u16u8_back.sv
rtl/utf16_to_utf8_encoder_top.sv
verif/utf16_to_utf8_encoder_top_test.sv
